// ----- rtl/packed_layout_body_decoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Packed layout body decoder - assertion macros
// Shared property wrappers for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PACKED_LAYOUT_BODY_DECODER_TOP_MACROS_SVH
`define PACKED_LAYOUT_BODY_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pld assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pld assertion failed");

`endif

// ----- rtl/pld_pkg.sv -----
// ----------------------------------------------------------------------------
// pld_pkg
// Types and constants shared by the packed layout body decoder.
// ----------------------------------------------------------------------------
package pld_pkg;

    localparam int BYTE_BITS = 8;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_THRESH,
        PH_CODE,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    localparam logic [1:0] KIND_THRESH  = 2'd0;
    localparam logic [1:0] KIND_DIGITAL = 2'd1;
    localparam logic [1:0] KIND_ANALOG  = 2'd2;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0] record_kind;
        logic       layer_sel;
        logic [4:0] slot_index;
        logic [4:0] action_code;
        logic [9:0] field_value;
        logic       last_record;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] bytes_left;
        logic [7:0] bit_buffer;
        logic [3:0] bits_held;
        logic [9:0] field_accum;
        logic [3:0] bits_needed;
        logic [4:0] slot;
        logic       layer;
        logic [4:0] pending_code;
    } t_parse_state;

    typedef struct packed {
        logic consume;
        logic emit;
    } t_step_ctl;

endpackage

// ----- rtl/packed_layout_body_decoder_top.sv -----
// ----------------------------------------------------------------------------
// packed_layout_body_decoder_top
// Decodes a packed layout body byte stream into threshold and action records.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_data (t_out_item)
//   cfg       input      i_cfg_we                   i_cfg_wdata (code limit)
//
// A new byte is taken only once the bits of the last one are used up, one field
// take per parse step (a layer end drops the bits left over); the single-take
// parse step in pld_step sets this.
// Byte to record: input register, parse step, output register. A full output
// register stalls the parser only if it is not read and a step has a record.
// Synchronous active-low reset returns the parser to idle, limit to 16.
// ----------------------------------------------------------------------------
`include "packed_layout_body_decoder_top_macros.svh"

module packed_layout_body_decoder_top #(
    parameter int SLOTS      = 20,
    parameter int CODE_BITS  = 5,
    parameter int VALUE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pld_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pld_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata
);
    import pld_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_step_ctl    step_ctl;
    t_out_item    step_result;
    t_in_item     r_in;
    logic         r_in_valid;
    t_out_item    r_out;
    logic         r_out_valid;
    logic [4:0]   r_limit;
    logic         stall;
    logic         consume;

    pld_step #(
        .SLOTS      (SLOTS),
        .CODE_BITS  (CODE_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_state    (r_state),
        .i_in_valid (r_in_valid),
        .i_in       (r_in),
        .i_limit    (r_limit),
        .o_state    (n_state),
        .o_ctl      (step_ctl),
        .o_result   (step_result)
    );

    assign stall       = step_ctl.emit && r_out_valid && !i_out_ready;
    assign consume     = step_ctl.consume && !stall;
    assign o_in_ready  = !r_in_valid || consume;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (!stall) begin
                r_state <= n_state;
            end
            r_in_valid <= (r_in_valid && !consume) || (i_in_valid && o_in_ready);
            if (step_ctl.emit && !stall) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (step_ctl.emit && !stall) begin
            r_out <= step_result;
        end
    end

    `PLD_ASSERT_NOW(a_held_in_field, i_clk, i_rst_n, r_state.bits_held != 4'd0,
        r_state.phase == PH_CODE || r_state.phase == PH_VALUE)
    `PLD_ASSERT_NOW(a_need_in_field, i_clk, i_rst_n,
        r_state.phase == PH_CODE || r_state.phase == PH_VALUE, r_state.bits_needed != 4'd0)
    `PLD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, stall, $stable(r_state))
    `PLD_ASSERT_NEXT(a_start_thresh, i_clk, i_rst_n, consume && r_in.body_start,
        r_state.phase == PH_THRESH)

endmodule

// ----- rtl/pld_step.sv -----
// ----------------------------------------------------------------------------
// pld_step
// One parse step: a single field take from the held bits or a fresh byte,
// with the resulting next parse state and at most one decoded record.
// ----------------------------------------------------------------------------
module pld_step #(
    parameter int SLOTS      = 20,
    parameter int CODE_BITS  = 5,
    parameter int VALUE_BITS = 10
) (
    input  pld_pkg::t_parse_state i_state,
    input  logic                  i_in_valid,
    input  pld_pkg::t_in_item     i_in,
    input  logic [4:0]            i_limit,
    output pld_pkg::t_parse_state o_state,
    output pld_pkg::t_step_ctl    o_ctl,
    output pld_pkg::t_out_item    o_result
);
    import pld_pkg::*;

    logic       have_bits;
    logic       load;
    logic       start;
    logic       in_field;
    logic       do_take;
    logic       field_done;
    logic       code_done;
    logic       go_analog;
    logic       slot_done;
    logic       layer_end;
    logic       has_mod;
    logic [7:0] src_buf;
    logic [3:0] src_held;
    logic [7:0] bl_dec;
    logic [7:0] bl_cur;
    logic [3:0] take;
    logic [7:0] shifted;
    logic [8:0] mask;
    logic [9:0] acc_new;
    logic [9:0] code_diff;
    logic [3:0] held_new;
    logic [3:0] need_new;
    logic [5:0] slot_inc;
    t_phase     n_phase;

    // field take
    always_comb begin
        have_bits = i_state.bits_held != 4'd0;
        load      = !have_bits && i_in_valid;
        start     = load && i_in.body_start;
        src_buf   = have_bits ? i_state.bit_buffer : i_in.data_byte;
        src_held  = have_bits ? i_state.bits_held : 4'(BYTE_BITS);
        bl_dec    = i_state.bytes_left - 8'(i_state.bytes_left != 8'd0);
        bl_cur    = have_bits ? i_state.bytes_left : bl_dec;
        take      = (src_held < i_state.bits_needed) ? src_held : i_state.bits_needed;
        if (take == 4'd0) begin
            take = 4'd1;
        end
        shifted   = src_buf >> (src_held - take);
        mask      = (9'd1 << take) - 9'd1;
        acc_new   = (i_state.field_accum << take) | {2'b00, shifted & mask[7:0]};
        held_new  = src_held - take;
        need_new  = (i_state.bits_needed > take) ? (i_state.bits_needed - take) : 4'd0;
        code_diff = acc_new - {5'b00000, i_limit};
    end

    // slot and layer decisions
    always_comb begin
        in_field   = (i_state.phase == PH_CODE) || (i_state.phase == PH_VALUE);
        do_take    = have_bits || (load && !start && in_field);
        field_done = do_take && (need_new == 4'd0);
        code_done  = field_done && (i_state.phase == PH_CODE);
        go_analog  = code_done && (acc_new > {5'b00000, i_limit});
        slot_done  = (code_done && !go_analog) || (field_done && (i_state.phase == PH_VALUE));
        slot_inc   = {1'b0, i_state.slot} + 6'd1;
        layer_end  = slot_done && (slot_inc >= 6'(SLOTS));
        has_mod    = layer_end && !i_state.layer &&
                     ((held_new == 4'd0) ? (bl_cur > 8'd1) : (bl_cur != 8'd0));
    end

    // next phase
    always_comb begin
        n_phase = i_state.phase;
        if (start) begin
            n_phase = PH_THRESH;
        end else if (load && (i_state.phase == PH_THRESH || i_state.phase == PH_SKIP)) begin
            n_phase = PH_CODE;
        end else if (go_analog) begin
            n_phase = PH_VALUE;
        end else if (layer_end) begin
            if (!has_mod) begin
                n_phase = PH_IDLE;
            end else if (held_new == 4'd0) begin
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_CODE;
            end
        end else if (slot_done) begin
            n_phase = PH_CODE;
        end
    end

    // datapath
    always_comb begin
        o_state = i_state;
        if (start) begin
            o_state.bytes_left   = i_in.data_byte;
            o_state.bit_buffer   = '0;
            o_state.bits_held    = '0;
            o_state.field_accum  = '0;
            o_state.bits_needed  = '0;
            o_state.slot         = '0;
            o_state.layer        = 1'b0;
            o_state.pending_code = '0;
        end else if (load && (i_state.phase == PH_THRESH || i_state.phase == PH_SKIP)) begin
            o_state.bytes_left  = bl_dec;
            o_state.layer       = i_state.phase == PH_SKIP;
            o_state.slot        = '0;
            o_state.field_accum = '0;
            o_state.bits_needed = 4'(CODE_BITS);
        end else if (do_take) begin
            o_state.bytes_left  = bl_cur;
            o_state.bit_buffer  = src_buf;
            o_state.bits_held   = held_new;
            o_state.field_accum = acc_new;
            o_state.bits_needed = need_new;
            if (field_done) begin
                o_state.field_accum = '0;
                o_state.bits_needed = 4'(CODE_BITS);
            end
            if (go_analog) begin
                o_state.pending_code = code_diff[4:0];
                o_state.bits_needed  = 4'(VALUE_BITS);
            end
            if (slot_done) begin
                o_state.slot = slot_inc[4:0];
            end
            if (layer_end) begin
                o_state.bits_held = '0;
                if (has_mod) begin
                    o_state.layer = 1'b1;
                    o_state.slot  = '0;
                end
            end
        end
        o_state.phase = n_phase;
    end

    // record
    always_comb begin
        o_ctl.consume = load;
        o_ctl.emit    = (load && !start && (i_state.phase == PH_THRESH)) || slot_done;
        o_result      = '0;
        if (slot_done) begin
            o_result.record_kind = (i_state.phase == PH_VALUE) ? KIND_ANALOG : KIND_DIGITAL;
            o_result.layer_sel   = i_state.layer;
            o_result.slot_index  = i_state.slot;
            o_result.action_code = (i_state.phase == PH_VALUE) ? i_state.pending_code
                                                               : acc_new[4:0];
            o_result.field_value = (i_state.phase == PH_VALUE) ? acc_new : 10'd0;
            o_result.last_record = layer_end && !has_mod;
        end else begin
            o_result.record_kind = KIND_THRESH;
            o_result.field_value = {2'b00, i_in.data_byte};
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed layout body decoder. A short table of
// hand-picked bytes comes first, then random bodies (well-formed, wrong
// length, cut short, plus loose noise) under several code limits. Every
// accepted byte is run through a bit-level model of the parser and every
// output transfer is compared with the oldest predicted record.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pld_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS = 70;
    localparam t_out_item NO_REC = '0;

    typedef struct {
        logic       start;
        logic [7:0] data;
        bit         typed;
        t_out_item  rec;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;

    packed_layout_body_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // decoder model state
    logic [4:0]  dec_limit = LIMIT_RESET;
    t_phase      dec_phase = PH_IDLE;
    logic [7:0]  dec_left = '0;
    int unsigned dec_held = 0;
    logic [9:0]  dec_accum = '0;
    int unsigned dec_need = 0;
    int unsigned dec_slot = 0;
    logic        dec_layer = 1'b0;
    logic [4:0]  dec_pending = '0;

    t_out_item pending_records[$];
    t_dir_row  dir_tab[$];

    int  cycle_count = 0;
    int  items_sent = 0;
    int  bodies_sent = 0;
    int  records_checked = 0;
    int  mismatches = 0;
    int  in_calm = 0;
    int  out_calm = 0;
    int  out_hold = 0;
    bit  idling_on = 1'b1;

    always #5ns i_clk = ~i_clk;

    function automatic void open_layer(input logic layer);
        dec_phase = PH_CODE;
        dec_layer = layer;
        dec_slot  = 0;
        dec_accum = '0;
        dec_need  = 5;
    endfunction

    function automatic void decode_byte(input t_in_item it, ref t_out_item recs[$]);
        int unsigned take;
        int unsigned tmp;
        logic [7:0]  cur_byte;
        logic [9:0]  c;
        bit          done;
        bit          lend;
        bit          more;
        t_out_item   r;
        recs = {};
        if (it.body_start) begin
            dec_phase   = PH_THRESH;
            dec_left    = it.data_byte;
            dec_held    = 0;
            dec_accum   = '0;
            dec_need    = 0;
            dec_slot    = 0;
            dec_layer   = 1'b0;
            dec_pending = '0;
            return;
        end
        if (dec_phase == PH_IDLE) return;
        if (dec_left != 0) dec_left = dec_left - 8'd1;
        if (dec_phase == PH_THRESH) begin
            r = '0;
            r.record_kind = KIND_THRESH;
            r.field_value = {2'b00, it.data_byte};
            recs.insert(recs.size(), r);
            open_layer(1'b0);
            return;
        end
        if (dec_phase == PH_SKIP) begin
            open_layer(1'b1);
            return;
        end
        cur_byte = it.data_byte;
        dec_held = 8;
        while (dec_held > 0 && (dec_phase == PH_CODE || dec_phase == PH_VALUE)) begin
            take = (dec_held < dec_need) ? dec_held : dec_need;
            if (take == 0) take = 1;
            tmp = (int'(dec_accum) << take)
                | ((int'(cur_byte) >> (dec_held - take)) & ((1 << take) - 1));
            dec_accum = 10'(tmp);
            dec_held -= take;
            dec_need = (dec_need > take) ? dec_need - take : 0;
            if (dec_need != 0) continue;
            done = 1'b0;
            r = '0;
            if (dec_phase == PH_CODE) begin
                c = dec_accum;
                dec_accum = '0;
                if (c > dec_limit) begin
                    dec_pending = 5'(c - dec_limit);
                    dec_phase = PH_VALUE;
                    dec_need = 10;
                end else begin
                    r.record_kind = KIND_DIGITAL;
                    r.action_code = c[4:0];
                    done = 1'b1;
                    dec_need = 5;
                end
            end else begin
                r.record_kind = KIND_ANALOG;
                r.action_code = dec_pending;
                r.field_value = dec_accum;
                dec_accum = '0;
                dec_phase = PH_CODE;
                dec_need = 5;
                done = 1'b1;
            end
            if (done) begin
                lend = (dec_slot + 1 >= 20);
                more = 1'b0;
                if (lend && dec_layer == 1'b0)
                    more = (dec_held == 0) ? (dec_left > 1) : (dec_left > 0);
                r.layer_sel   = dec_layer;
                r.slot_index  = 5'(dec_slot);
                r.last_record = lend && !more;
                recs.insert(recs.size(), r);
                dec_slot++;
                if (lend) begin
                    if (more) begin
                        if (dec_held == 0) dec_phase = PH_SKIP;
                        else open_layer(1'b1);
                    end else begin
                        dec_phase = PH_IDLE;
                    end
                    dec_held = 0;
                    break;
                end
            end
        end
    endfunction

    function automatic t_out_item thr_rec(input logic [7:0] b);
        t_out_item r;
        r = '0;
        r.record_kind = KIND_THRESH;
        r.field_value = {2'b00, b};
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic start, input logic [7:0] data,
                                         input bit typed, input t_out_item rec);
        t_dir_row row;
        row.start = start;
        row.data  = data;
        row.typed = typed;
        row.rec   = rec;
        return row;
    endfunction

    function automatic logic [4:0] pick_code(input int bias);
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) begin
            if (p < 2) return 5'd0;
            if (p < 4) return 5'd31;
            if (p < 6) return dec_limit;
            return (dec_limit == 5'd31) ? 5'd31 : dec_limit + 5'd1;
        end
        if (dec_limit != 5'd31 && $urandom_range(0, 3) < bias)
            return 5'($urandom_range(int'(dec_limit) + 1, 31));
        return 5'($urandom_range(0, int'(dec_limit)));
    endfunction

    // one layer of 20 slots, padded to a byte; the base layer gets a spare byte
    // when it ends on a boundary
    function automatic void build_layer(ref logic [7:0] bytes[$], input bit base,
                                        input int bias);
        bit          bq[$];
        logic [4:0]  code;
        logic [9:0]  value;
        logic [7:0]  b;
        int          p;
        for (int s = 0; s < 20; s++) begin
            code = pick_code(bias);
            for (int k = 4; k >= 0; k--) bq.insert(bq.size(), code[k]);
            if (code > dec_limit) begin
                p = $urandom_range(0, 9);
                value = (p == 0) ? 10'd0 : (p == 1) ? 10'h3FF : 10'($urandom);
                for (int k = 9; k >= 0; k--) bq.insert(bq.size(), value[k]);
            end
        end
        if (bq.size() % 8 == 0 && base) begin
            repeat (8) bq.insert(bq.size(), 1'($urandom));
        end
        while (bq.size() % 8 != 0) bq.insert(bq.size(), 1'($urandom));
        for (int i = 0; i < bq.size(); i += 8) begin
            for (int k = 0; k < 8; k++) b[7 - k] = bq[i + k];
            bytes.insert(bytes.size(), b);
        end
    endfunction

    task automatic send_item(input logic start, input logic [7:0] data,
                             input bit typed, input t_out_item rec);
        t_out_item recs[$];
        t_in_item  it;
        int        gap;
        it.data_byte  = data;
        it.body_start = start;
        @(negedge i_clk);
        if (idling_on) begin
            if (in_calm > 0) begin
                in_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
                in_calm = $urandom_range(10, 40);
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 11);
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (start || dec_phase != PH_IDLE) items_sent++;
        decode_byte(it, recs);
        if (typed) pending_records.insert(pending_records.size(), rec);
        else foreach (recs[i]) pending_records.insert(pending_records.size(), recs[i]);
    endtask

    task automatic send_body(input int mode);
        logic [7:0] bytes[$];
        int         bias;
        int         len;
        int         cut;
        int         p;
        bias = $urandom_range(0, 3);
        p = $urandom_range(0, 9);
        bytes.insert(bytes.size(), (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
        build_layer(bytes, 1'b1, bias);
        if ($urandom_range(0, 1)) build_layer(bytes, 1'b0, bias);
        len = bytes.size();
        if (mode == 1) len = $urandom_range(0, 255);
        cut = (mode == 2) ? $urandom_range(1, bytes.size()) : bytes.size();
        send_item(1'b1, 8'(len), 1'b0, NO_REC);
        for (int i = 0; i < cut; i++) send_item(1'b0, bytes[i], 1'b0, NO_REC);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom), 1'b0, NO_REC);
        end
        bodies_sent++;
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [4:0] lim);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dec_limit = lim;
    endtask

    task automatic check_record(input t_out_item got);
        t_out_item want;
        if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: kind=%0d layer=%0d slot=%0d code=%0d value=%0d last=%0d",
                         got.record_kind, got.layer_sel, got.slot_index,
                         got.action_code, got.field_value, got.last_record);
            return;
        end
        want = pending_records.pop_front();
        records_checked++;
        if (got.record_kind !== want.record_kind || got.layer_sel !== want.layer_sel ||
            got.slot_index !== want.slot_index || got.action_code !== want.action_code ||
            got.field_value !== want.field_value || got.last_record !== want.last_record) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch at record %0d", records_checked);
                $display("    expected kind=%0d layer=%0d slot=%0d code=%0d value=%0d last=%0d",
                         want.record_kind, want.layer_sel, want.slot_index,
                         want.action_code, want.field_value, want.last_record);
                $display("    got kind=%0d layer=%0d slot=%0d code=%0d value=%0d last=%0d",
                         got.record_kind, got.layer_sel, got.slot_index,
                         got.action_code, got.field_value, got.last_record);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_record(o_out_data);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, pending_records.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!idling_on) begin
            i_out_ready <= 1'b1;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (out_calm > 0) out_calm--;
            else if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0) out_hold = $urandom_range(1, 11);
        end
    end

    initial begin
        logic [4:0] limits[5];
        int         target;
        int         r;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset limit
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hA5, 1'b0, NO_REC));   // idle, ignored
        dir_tab.insert(dir_tab.size(), dir_row(1'b1, 8'h00, 1'b0, NO_REC));   // zero length
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hFF, 1'b1, thr_rec(8'hFF)));
        for (int k = 0; k < 13; k++)                                          // all code 0
            dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'h00, 1'b0, NO_REC));
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hFF, 1'b0, NO_REC));   // after body end
        dir_tab.insert(dir_tab.size(), dir_row(1'b1, 8'h03, 1'b0, NO_REC));
        dir_tab.insert(dir_tab.size(), dir_row(1'b1, 8'hFF, 1'b0, NO_REC));   // restart early
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'h00, 1'b1, thr_rec(8'h00)));
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hFF, 1'b0, NO_REC));   // code 31, analog
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hFF, 1'b0, NO_REC));   // value 1023
        dir_tab.insert(dir_tab.size(), dir_row(1'b1, 8'h01, 1'b0, NO_REC));   // restart mid-body
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'h80, 1'b1, thr_rec(8'h80)));
        dir_tab.insert(dir_tab.size(), dir_row(1'b0, 8'hF8, 1'b0, NO_REC));
        foreach (dir_tab[i])
            send_item(dir_tab[i].start, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].rec);

        limits[0] = 5'd31;
        limits[1] = 5'd0;
        limits[2] = 5'($urandom_range(1, 30));
        limits[3] = 5'($urandom);
        limits[4] = LIMIT_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            wait_quiet();
            write_limit(limits[ph]);
            if (ph == 4) idling_on = 1'b0;
            target = items_sent + PHASE_ITEMS;
            send_body(0);
            while (items_sent < target) begin
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    send_body(0);
                end else if (r < 16) begin
                    send_body(1);
                end else if (r < 18) begin
                    send_body(2);
                end else begin
                    repeat ($urandom_range(3, 12))
                        send_item(1'($urandom_range(0, 7) == 0), 8'($urandom), 1'b0, NO_REC);
                end
            end
        end
        wait_quiet();

        $display("covered %0d parsed input transfers in %0d random bodies plus a directed table,",
                 items_sent, bodies_sent);
        $display("code limits 16/31/0/%0d/%0d/16, %0d records compared, %0d mismatches",
                 limits[2], limits[3], records_checked, mismatches);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pld_pkg.sv
rtl/pld_step.sv
rtl/packed_layout_body_decoder_top.sv
sim/tb_top.sv
